@@ design/tlfq_pkg.sv @@
package tlfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 8;
  localparam int BURST_BITS  = 16;
  localparam int RUN_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int ADDR_W      = 4;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [1:0] REG_TOP_SLICE   = 2'd0;
  localparam logic [1:0] REG_TOP_QUANTUM = 2'd1;
  localparam logic [1:0] REG_LOW_SLICE   = 2'd2;
  localparam logic [1:0] REG_LOW_QUANTUM = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  new_pid;
    logic [15:0] new_burst;
  } tick_t;

  typedef struct packed {
    logic [31:0] now;
    logic        ran;
    logic [7:0]  ran_pid;
    logic        ran_queue;
    logic        finished;
    logic [31:0] completion_time;
    logic        add_dropped;
  } result_t;

  typedef struct packed {
    logic [PID_BITS-1:0]   pid;
    logic [BURST_BITS-1:0] remaining;
    logic [RUN_BITS-1:0]   run;
  } entry_t;

  // write requests into one queue; later fields take priority
  typedef struct packed {
    logic   add_en;
    idx_t   add_idx;
    entry_t add_data;
    logic   upd_en;
    idx_t   upd_idx;
    entry_t upd_data;
    logic   req_en;
    idx_t   req_idx;
    entry_t req_data;
  } qwr_t;

  typedef struct packed {
    logic [1:0][CFG_BITS-1:0] slice;
    logic [1:0][CFG_BITS-1:0] quantum;
  } cfg_t;

  // head plus offset, offset at most QUEUE_DEPTH
  function automatic idx_t wrap_idx(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      r = s - SUM_W'(QUEUE_DEPTH);
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

@@ design/tlfq_regs.sv @@
module tlfq_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [tlfq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output tlfq_pkg::cfg_t        cfg
);
  import tlfq_pkg::*;

  logic [1:0] reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice[0]   <= CFG_BITS'(4);
      cfg.quantum[0] <= CFG_BITS'(2);
      cfg.slice[1]   <= CFG_BITS'(4);
      cfg.quantum[1] <= CFG_BITS'(2);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_TOP_SLICE:   cfg.slice[0]   <= pwdata[CFG_BITS-1:0];
        REG_TOP_QUANTUM: cfg.quantum[0] <= pwdata[CFG_BITS-1:0];
        REG_LOW_SLICE:   cfg.slice[1]   <= pwdata[CFG_BITS-1:0];
        REG_LOW_QUANTUM: cfg.quantum[1] <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOP_SLICE:   prdata = 32'(cfg.slice[0]);
      REG_TOP_QUANTUM: prdata = 32'(cfg.quantum[0]);
      REG_LOW_SLICE:   prdata = 32'(cfg.slice[1]);
      REG_LOW_QUANTUM: prdata = 32'(cfg.quantum[1]);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ design/tlfq_queue.sv @@
module tlfq_queue (
  input  logic             clk,
  input  tlfq_pkg::qwr_t   wr,
  input  tlfq_pkg::idx_t   rd_idx,
  output tlfq_pkg::entry_t rd_data
);
  import tlfq_pkg::*;

  entry_t entries [QUEUE_DEPTH];

  // requeue beats head update beats add where slots coincide
  always_ff @(posedge clk) begin
    if (wr.add_en) begin
      entries[wr.add_idx] <= wr.add_data;
    end
    if (wr.upd_en) begin
      entries[wr.upd_idx] <= wr.upd_data;
    end
    if (wr.req_en) begin
      entries[wr.req_idx] <= wr.req_data;
    end
  end

  assign rd_data = entries[rd_idx];

endmodule

@@ design/two_level_feedback_queue_scheduler.sv @@
// Two-level feedback queue scheduler, one time tick per transaction.
//
// tick channel (tick_valid/tick_ready/tick_data): each transaction is one
// tick, optionally adding a process to the active queue first.
// result channel (result_valid/result_ready/result_data): one result per
// tick, in order, giving the tick count, the process that ran, its queue,
// completion and whether the add was dropped.
// APB port: four 16-bit registers at byte addresses 0, 4, 8 and 12
// (top slice, top quantum, low slice, low quantum); pready is always high.
//
// The tick sits in the input register while the queue update and result
// are computed, and both are registered together when the tick advances
// out of the input register. Throughput is one tick per cycle while the
// result is taken, set by the single read of each queue head and the three
// write ports of each queue store.
// A synchronous reset empties both queues, clears the tick count and slice
// timers, selects the top queue and loads the register defaults.
// When result_ready is low the result register holds, the input register
// fills, and tick_ready then drops until the result is taken.
module two_level_feedback_queue_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlfq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        tick_valid,
  output logic                        tick_ready,
  input  tlfq_pkg::tick_t             tick_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output tlfq_pkg::result_t           result_data
);
  import tlfq_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  tick_t   s1_data;
  logic    advance;

  idx_t    head [2];
  cnt_t    count [2];
  logic [CFG_BITS-1:0] timer [2];
  logic [31:0] tick_count;
  logic    active;

  idx_t    head_next [2];
  cnt_t    count_next [2];
  logic [CFG_BITS-1:0] timer_next [2];
  logic    active_next;

  qwr_t    qwr [2];
  entry_t  qrd [2];

  logic    q;
  idx_t    h;
  cnt_t    c;
  cnt_t    c1;
  logic    full;
  logic    added;
  logic    dropped;
  idx_t    add_idx;
  entry_t  new_ent;
  entry_t  hd;
  logic    ran;
  logic    fin;
  logic [BURST_BITS-1:0] rem_dec;
  logic [RUN_BITS-1:0]   run_inc;
  logic    upd;
  logic    quant_hit;
  logic    pop;
  logic    tq;
  idx_t    req_idx;
  logic [CFG_BITS-1:0] tmr_inc;
  logic [31:0] now;
  result_t res;

  tlfq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlfq_queue u_queue_top (
    .clk     (clk),
    .wr      (qwr[0]),
    .rd_idx  (head[0]),
    .rd_data (qrd[0])
  );

  tlfq_queue u_queue_low (
    .clk     (clk),
    .wr      (qwr[1]),
    .rd_idx  (head[1]),
    .rd_data (qrd[1])
  );

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign tick_ready = !s1_valid || advance;

  always_comb begin
    q       = active;
    h       = head[q];
    c       = count[q];
    full    = (c == CNT_W'(QUEUE_DEPTH));
    added   = s1_data.kind && !full;
    dropped = s1_data.kind && full;
    add_idx = wrap_idx(SUM_W'(h) + SUM_W'(c));
    c1      = c + CNT_W'(added);

    new_ent.pid       = PID_BITS'(s1_data.new_pid);
    new_ent.remaining = BURST_BITS'(s1_data.new_burst);
    new_ent.run       = '0;

    // an empty queue runs the process just added
    hd = (c == '0) ? new_ent : qrd[q];

    ran       = (c1 != '0);
    fin       = ran && (hd.remaining <= BURST_BITS'(1));
    rem_dec   = hd.remaining - BURST_BITS'(1);
    run_inc   = hd.run + RUN_BITS'(1);
    upd       = ran && !fin;
    quant_hit = upd && (run_inc == cfg.quantum[q]);
    pop       = fin || quant_hit;

    // demotion falls back to the top queue when the lower one is full
    if (q == 1'b0) begin
      tq = (count[1] != CNT_W'(QUEUE_DEPTH));
    end else begin
      tq = 1'b1;
    end
    if (tq == q) begin
      req_idx = wrap_idx(SUM_W'(h) + SUM_W'(c1));
    end else begin
      req_idx = wrap_idx(SUM_W'(head[1]) + SUM_W'(count[1]));
    end

    head_next  = head;
    count_next = count;
    timer_next = timer;
    if (pop) begin
      head_next[q] = wrap_idx(SUM_W'(h) + SUM_W'(1));
    end
    count_next[q] = c1 - CNT_W'(pop);
    if (quant_hit) begin
      count_next[tq] = count_next[tq] + CNT_W'(1);
    end

    tmr_inc     = timer[q] + CFG_BITS'(1);
    active_next = active;
    if (tmr_inc == cfg.slice[q]) begin
      timer_next[q] = '0;
      active_next   = ~q;
    end else begin
      timer_next[q] = tmr_inc;
    end

    for (int i = 0; i < 2; i++) begin
      qwr[i].add_en   = advance && added && (q == 1'(i));
      qwr[i].add_idx  = add_idx;
      qwr[i].add_data = new_ent;
      qwr[i].upd_en   = advance && upd && (q == 1'(i));
      qwr[i].upd_idx  = h;
      qwr[i].upd_data = '{pid: hd.pid, remaining: rem_dec, run: run_inc};
      qwr[i].req_en   = advance && quant_hit && (tq == 1'(i));
      qwr[i].req_idx  = req_idx;
      qwr[i].req_data = '{pid: hd.pid, remaining: rem_dec, run: '0};
    end

    now                 = tick_count + 32'd1;
    res.now             = now;
    res.ran             = ran;
    res.ran_pid         = ran ? 8'(hd.pid) : 8'd0;
    res.ran_queue       = q;
    res.finished        = fin;
    res.completion_time = fin ? now : 32'd0;
    res.add_dropped     = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      head[0]      <= '0;
      head[1]      <= '0;
      count[0]     <= '0;
      count[1]     <= '0;
      timer[0]     <= '0;
      timer[1]     <= '0;
      tick_count   <= '0;
      active       <= 1'b0;
    end else begin
      if (tick_valid && tick_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        head         <= head_next;
        count        <= count_next;
        timer        <= timer_next;
        tick_count   <= now;
        active       <= active_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      s1_data <= tick_data;
    end
    if (advance) begin
      result_data <= res;
    end
  end

endmodule
